// File: rtl/hcsr_pkg.sv
package hcsr_pkg;

  // Internal numbers are signed Q16.32, carried with two guard bits.
  typedef logic signed [49:0] val_t;

  localparam val_t QLIM    = 50'sd140737488355327;
  localparam val_t QONE    = 50'sd4294967296;
  localparam val_t C_SCALE = 50'sd858993459;
  localparam val_t C_CLIP  = 50'sd77309411328;
  localparam val_t C_TWOKS = 50'sd6871947674;
  localparam val_t C_V0    = 50'sd9019431322;
  localparam val_t C_K3K4  = 50'sd21665723915;
  localparam val_t C_KR    = 50'sd30451318129;
  localparam val_t C_N0    = 50'sd138727443661;
  localparam val_t C_INVKP = 50'sd1301505241;
  localparam val_t C_THR   = 50'sd10737418240;

  localparam logic [47:0] R_RELEASE = 48'd123299921;
  localparam logic [47:0] R_DEPL    = 48'd621881200;
  localparam logic [47:0] R_VES     = 48'd7429122067;
  localparam logic [47:0] R_RATE    = 48'd24516102822;

  localparam logic [2:0] CFG_GAIN = 3'd0;
  localparam logic [2:0] CFG_KA1  = 3'd1;
  localparam logic [2:0] CFG_KB1  = 3'd2;
  localparam logic [2:0] CFG_KA2  = 3'd3;
  localparam logic [2:0] CFG_KB2  = 3'd4;
  localparam logic [2:0] CFG_KA3  = 3'd5;
  localparam logic [2:0] CFG_KB3  = 3'd6;

  localparam logic [15:0] SIG_END = 16'd65514;

  // Logistic curve sampled at half-unit steps, Q0.16.
  function automatic logic [15:0] sig_tab(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:  v = 16'd32768;
      5'd1:  v = 16'd40793;
      5'd2:  v = 16'd47911;
      5'd3:  v = 16'd53581;
      5'd4:  v = 16'd57724;
      5'd5:  v = 16'd60565;
      5'd6:  v = 16'd62428;
      5'd7:  v = 16'd63615;
      5'd8:  v = 16'd64357;
      5'd9:  v = 16'd64816;
      5'd10: v = 16'd65097;
      5'd11: v = 16'd65269;
      5'd12: v = 16'd65374;
      5'd13: v = 16'd65438;
      5'd14: v = 16'd65476;
      5'd15: v = 16'd65500;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

  // Saturate a grown sum back into the internal range.
  function automatic val_t sat(input logic signed [50:0] v);
    logic signed [50:0] lim;
    val_t r;
    lim = 51'(QLIM);
    if (v > lim) r = QLIM;
    else if (v < -lim) r = -QLIM;
    else r = v[49:0];
    return r;
  endfunction

endpackage

// File: rtl/hcsr_ram.sv
module hcsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/hcsr_mul.sv
module hcsr_mul import hcsr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  val_t a_i,
  input  val_t b_i,
  output logic done_o,
  output val_t y_o
);

  // Sign-magnitude product |a|*|b|/2^32 from four partial products,
  // one 32x32 multiply per cycle, saturated to the internal range.
  logic        busy_q;
  logic [2:0]  phase_q;
  logic        neg_q;
  logic [47:0] am_q, bm_q;
  logic [63:0] prod_q;
  logic [50:0] acc_q;
  logic        big_q;
  logic        done_q;
  val_t        y_q;

  val_t        a_abs, b_abs;
  logic [31:0] mx, my;
  logic [50:0] sum_fin, m_fin;

  assign a_abs = a_i[49] ? -a_i : a_i;
  assign b_abs = b_i[49] ? -b_i : b_i;

  always_comb begin
    mx = (phase_q == 3'd2 || phase_q == 3'd3) ? am_q[31:0] : {16'b0, am_q[47:32]};
    my = (phase_q == 3'd0 || phase_q == 3'd2) ? {16'b0, bm_q[47:32]} : bm_q[31:0];
    sum_fin = acc_q + 51'(prod_q[63:32]);
    if (big_q || sum_fin > 51'(QLIM)) m_fin = 51'(QLIM);
    else m_fin = sum_fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 3'd0;
      done_q  <= 1'b0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      phase_q <= 3'd0;
      done_q  <= 1'b0;
    end else if (busy_q) begin
      phase_q <= phase_q + 3'd1;
      if (phase_q == 3'd4) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= a_i[49] ^ b_i[49];
      am_q  <= a_abs[47:0];
      bm_q  <= b_abs[47:0];
    end else if (busy_q) begin
      prod_q <= 64'(mx) * 64'(my);
      case (phase_q)
        3'd1: begin
          big_q <= (prod_q[31:0] >= 32'd32768);
          acc_q <= {prod_q[18:0], 32'b0};
        end
        3'd2, 3'd3: acc_q <= acc_q + prod_q[50:0];
        3'd4: y_q <= neg_q ? -m_fin[49:0] : m_fin[49:0];
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign y_o    = y_q;

endmodule

// File: rtl/hair_cell_synapse_rate_core.sv
// Hair cell synapse firing rate, one item per sample of any channel.
// Input channel: in_valid_i / in_ready_o with channel_i and sample_i
// (signed Q16.16). Output channel: out_valid_o / out_ready_i with
// channel_out_o and rate_o (unsigned Q16.16, saturating), one result item
// per input item, in input order.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 is the gain, 1 to 6 the filter coefficients, 7 is ignored. The
// port is always ready and is meant to be written while the block is idle.
// Each item passes through the state read, the load, seventeen Q16.32
// products that run one after the other through the single 32x32 multiplier,
// fourteen add and table steps among them, and the handoff to the output
// register. No new item is accepted while one is in work. A channel
// outside the configured range skips the computation and gives rate zero.
// The next item is taken as soon as a result is handed to the output
// register, so a stalled receiver blocks only once a second result is ready.
// After reset, a clearing pass loads the initial filter state into every
// channel; no item is accepted until it is done.
module hair_cell_synapse_rate_core import hcsr_pkg::*; #(
  parameter int NUM_CHANNELS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [5:0]  channel_i,
  input  logic [31:0] sample_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  channel_out_o,
  output logic [31:0] rate_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SW = 5 * 48;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_LOAD  = 6'b001000,
    S_RUN   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  // Micro-program of the shared multiplier and adder.
  typedef enum logic [4:0] {
    ST_SCALE, ST_VOFF, ST_SLOPE, ST_LG1A, ST_LG2A, ST_LG3A, ST_ONEMD, ST_B,
    ST_SUMB, ST_K3K4, ST_KB1, ST_DSUM, ST_DEP, ST_KB2, ST_CSUM, ST_CAL,
    ST_KR, ST_NSUB, ST_R, ST_RSUM, ST_INVKP, ST_KB3, ST_VSUM, ST_VES,
    ST_THR, ST_DBL, ST_LG1B, ST_LG2B, ST_LG3B, ST_RES, ST_GAIN
  } step_e;

  typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_LG1, OP_LG3} op_e;

  typedef enum logic [3:0] {
    D_X, D_TA, D_TB, D_LZ, D_LM, D_LV, D_B, D_SUMB, D_DEP, D_CAL, D_R,
    D_VES, D_RES, D_RATE, D_NONE
  } dst_e;

  state_e state_q, state_d;
  step_e  step_q;

  logic [31:0] gain_q;
  logic [47:0] coef_q [6];

  logic [5:0]  ch_q;
  logic [31:0] s_q;
  logic        inrange_q;
  logic [AW-1:0] clr_q;

  val_t rel0_q, dep0_q, cal0_q, ves0_q, prate0_q;
  val_t ta_q, tb_q, lz_q, lm_q, lv_q, b_q, sumb_q, dep_q, cal_q, r_q, ves_q, res_q;
  logic        lg_big_q, lg_neg_q;
  logic [31:0] lg_base_q;
  logic [15:0] lg_diff_q;
  logic [30:0] lg_frac_q;
  logic [31:0] rate_val_q;

  logic        out_valid_q;
  logic [5:0]  ch_out_q;
  logic [31:0] rate_out_q;

  logic        mul_wait_q, mul_start, mul_done;
  val_t        mul_y;

  op_e  op;
  dst_e dst;
  val_t opa, opb, add_res, lg_res, res_val;
  logic step_fire;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata, ram_rdata;

  logic in_acc, out_load;
  logic ch_ok;

  val_t        lz_mag;
  logic [4:0]  lz_idx;
  logic [15:0] tab_lo, tab_hi;
  logic [32:0] lg_v;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign ch_ok       = (11'(channel_i) < 11'(NUM_CHANNELS));
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Operand and destination of each micro-step.
  always_comb begin
    op  = OP_ADD;
    dst = D_NONE;
    opa = '0;
    opb = '0;
    case (step_q)
      ST_SCALE: begin op = OP_MUL; dst = D_X;
        opa = {{2{s_q[31]}}, s_q, 16'b0}; opb = C_SCALE; end
      ST_VOFF:  begin dst = D_TA; opa = ta_q; opb = -C_V0; end
      ST_SLOPE: begin op = OP_MUL; dst = D_LZ; opa = C_TWOKS; opb = ta_q; end
      ST_LG1A, ST_LG1B: op = OP_LG1;
      ST_LG2A, ST_LG2B: begin op = OP_MUL; dst = D_LM;
        opa = {17'b0, lg_diff_q, 17'b0}; opb = {19'b0, lg_frac_q}; end
      ST_LG3A, ST_LG3B: begin op = OP_LG3; dst = D_LV; end
      ST_ONEMD: begin dst = D_TA; opa = QONE; opb = -dep0_q; end
      ST_B:     begin op = OP_MUL; dst = D_B; opa = ta_q; opb = lv_q; end
      ST_SUMB:  begin dst = D_SUMB; opa = b_q; opb = rel0_q; end
      ST_K3K4:  begin op = OP_MUL; dst = D_TA; opa = C_K3K4; opb = sumb_q; end
      ST_KB1:   begin op = OP_MUL; dst = D_TB; opa = {2'b0, coef_q[1]}; opb = dep0_q; end
      ST_DSUM:  begin dst = D_TA; opa = ta_q; opb = tb_q; end
      ST_DEP:   begin op = OP_MUL; dst = D_DEP; opa = {2'b0, coef_q[0]}; opb = ta_q; end
      ST_KB2:   begin op = OP_MUL; dst = D_TA; opa = {2'b0, coef_q[3]}; opb = cal0_q; end
      ST_CSUM:  begin dst = D_TA; opa = sumb_q; opb = ta_q; end
      ST_CAL:   begin op = OP_MUL; dst = D_CAL; opa = {2'b0, coef_q[2]}; opb = ta_q; end
      ST_KR:    begin op = OP_MUL; dst = D_TA; opa = cal_q; opb = C_KR; end
      ST_NSUB:  begin dst = D_TB; opa = C_N0; opb = -ves0_q; end
      ST_R:     begin op = OP_MUL; dst = D_R; opa = ta_q; opb = tb_q; end
      ST_RSUM:  begin dst = D_TA; opa = r_q; opb = prate0_q; end
      ST_INVKP: begin op = OP_MUL; dst = D_TA; opa = C_INVKP; opb = ta_q; end
      ST_KB3:   begin op = OP_MUL; dst = D_TB; opa = {2'b0, coef_q[5]}; opb = ves0_q; end
      ST_VSUM:  begin dst = D_TA; opa = ta_q; opb = tb_q; end
      ST_VES:   begin op = OP_MUL; dst = D_VES; opa = {2'b0, coef_q[4]}; opb = ta_q; end
      ST_THR:   begin dst = D_TB; opa = r_q; opb = -C_THR; end
      ST_DBL:   begin dst = D_LZ; opa = tb_q; opb = tb_q; end
      ST_RES:   begin op = OP_MUL; dst = D_RES; opa = tb_q; opb = lv_q; end
      ST_GAIN:  begin op = OP_MUL; dst = D_RATE; opa = res_q; opb = {18'b0, gain_q}; end
      default: ;
    endcase
  end

  assign add_res = sat(51'(opa) + 51'(opb));

  // Table lookup for the logistic curve, and the final interpolated value with its sign mirrored.
  always_comb begin
    lz_mag = lz_q[49] ? -lz_q : lz_q;
    lz_idx = {1'b0, lz_mag[34:31]};
    tab_lo = sig_tab(lz_idx);
    tab_hi = sig_tab(lz_idx + 5'd1);
    lg_v   = lg_big_q ? {1'b0, SIG_END, 16'b0} : ({1'b0, lg_base_q} + lm_q[32:0]);
    if (lg_neg_q) lg_v = 33'h1_0000_0000 - lg_v;
    lg_res = {17'b0, lg_v};
  end

  assign mul_start = (state_q == S_RUN) && (op == OP_MUL) && !mul_wait_q;
  assign step_fire = (state_q == S_RUN) && ((op != OP_MUL) || mul_done);
  assign res_val   = (op == OP_MUL) ? mul_y : ((op == OP_LG3) ? lg_res : add_res);

  hcsr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (mul_done),
    .y_o     (mul_y)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == AW'(NUM_CHANNELS - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_acc) state_d = ch_ok ? S_READ : S_DONE;
      S_READ:  state_d = S_LOAD;
      S_LOAD:  state_d = S_RUN;
      S_RUN:   if (step_fire && step_q == ST_GAIN) state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      step_q      <= ST_SCALE;
      clr_q       <= '0;
      mul_wait_q  <= 1'b0;
      out_valid_q <= 1'b0;
      gain_q      <= 32'd655360;
      for (int i = 0; i < 6; i++) coef_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
      if (state_q == S_LOAD) step_q <= ST_SCALE;
      else if (step_fire) step_q <= step_e'(step_q + 5'd1);
      if (mul_start) mul_wait_q <= 1'b1;
      else if (mul_done) mul_wait_q <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_GAIN: gain_q    <= cfg_data_i[31:0];
          CFG_KA1:  coef_q[0] <= cfg_data_i;
          CFG_KB1:  coef_q[1] <= cfg_data_i;
          CFG_KA2:  coef_q[2] <= cfg_data_i;
          CFG_KB2:  coef_q[3] <= cfg_data_i;
          CFG_KA3:  coef_q[4] <= cfg_data_i;
          CFG_KB3:  coef_q[5] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q      <= channel_i;
      s_q       <= sample_i;
      inrange_q <= ch_ok;
    end
    if (state_q == S_LOAD) begin
      rel0_q   <= {{2{ram_rdata[47]}},  ram_rdata[47:0]};
      dep0_q   <= {{2{ram_rdata[95]}},  ram_rdata[95:48]};
      cal0_q   <= {{2{ram_rdata[143]}}, ram_rdata[143:96]};
      ves0_q   <= {{2{ram_rdata[191]}}, ram_rdata[191:144]};
      prate0_q <= {{2{ram_rdata[239]}}, ram_rdata[239:192]};
    end
    if (step_fire && op == OP_LG1) begin
      lg_big_q  <= (lz_mag >= 50'sh8_0000_0000);
      lg_neg_q  <= lz_q[49];
      lg_base_q <= {tab_lo, 16'b0};
      lg_diff_q <= tab_hi - tab_lo;
      lg_frac_q <= lz_mag[30:0];
    end
    if (step_fire) begin
      case (dst)
        D_X:    ta_q   <= (res_val > C_CLIP) ? C_CLIP : res_val;
        D_TA:   ta_q   <= res_val;
        D_TB:   tb_q   <= res_val;
        D_LZ:   lz_q   <= res_val;
        D_LM:   lm_q   <= res_val;
        D_LV:   lv_q   <= res_val;
        D_B:    b_q    <= res_val;
        D_SUMB: sumb_q <= res_val;
        D_DEP:  dep_q  <= res_val;
        D_CAL:  cal_q  <= res_val;
        D_R:    r_q    <= res_val;
        D_VES:  ves_q  <= res_val;
        D_RES:  res_q  <= (r_q >= C_THR) ? res_val : '0;
        D_RATE: rate_val_q <= (res_val > 50'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : res_val[31:0];
        default: ;
      endcase
    end
    if (out_load) begin
      ch_out_q   <= ch_q;
      rate_out_q <= inrange_q ? rate_val_q : 32'd0;
    end
  end

  // State memory: one word per channel holding all five filter values.
  always_comb begin
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = {R_RATE, R_VES, R_RELEASE, R_DEPL, R_RELEASE};
    end else begin
      ram_we    = out_load && inrange_q;
      ram_waddr = AW'(ch_q);
      ram_wdata = {res_q[47:0], ves_q[47:0], cal_q[47:0], dep_q[47:0], b_q[47:0]};
    end
  end

  hcsr_ram #(
    .WIDTH (SW),
    .DEPTH (NUM_CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (AW'(ch_q)),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = ch_out_q;
  assign rate_o        = rate_out_q;

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

// Scoreboard for the synapse rate results: the predictor pushes the expected
// channel and rate of every accepted item, and each result item is checked
// against the oldest entry.
class rate_scoreboard;
  typedef struct packed {
    logic [5:0]  channel;
    logic [31:0] rate;
  } rate_item_t;

  rate_item_t  pending_rates[$];
  int unsigned mismatch_count;

  function void note_input(logic [5:0] channel, logic [31:0] rate);
    rate_item_t it;
    it.channel = channel;
    it.rate    = rate;
    pending_rates.push_back(it);
  endfunction

  function void check_result(logic [5:0] channel, logic [31:0] rate);
    rate_item_t it;
    if (pending_rates.size() == 0) begin
      report_mismatch($sformatf("unexpected result ch=%0d rate=%h", channel, rate));
      return;
    end
    it = pending_rates.pop_front();
    if (channel !== it.channel)
      report_mismatch($sformatf("channel got %0d want %0d", channel, it.channel));
    if (rate !== it.rate)
      report_mismatch($sformatf("rate ch=%0d got %h want %h", it.channel, rate, it.rate));
  endfunction

  function void report_mismatch(string msg);
    mismatch_count++;
    $display("MISMATCH %0t: %s", $time, msg);
  endfunction
endclass

module testbench;
  import hcsr_pkg::*;

  localparam int NCH = 64;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint SAT_LIM = 64'sd140737488355327;
  localparam longint ONE_Q   = 64'sd4294967296;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [5:0]  channel_i = '0;
  logic [31:0] sample_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  channel_out_o;
  logic [31:0] rate_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  hair_cell_synapse_rate_core #(.NUM_CHANNELS(NCH)) dut (.*);

  rate_scoreboard sb = new();

  // Predictor copy of the configuration and the per-channel filter state.
  logic [31:0] gain_q;
  longint      coef_q[6];
  longint      release_st[NCH];
  longint      depl_st[NCH];
  longint      calcium_st[NCH];
  longint      vesicle_st[NCH];
  longint      rate_st[NCH];
  longint      stall_cycles = 0;
  logic [15:0] sigma_pts[17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428,
                                 63615, 64357, 64816, 65097, 65269, 65374, 65438,
                                 65476, 65500, 65514};

  function automatic longint clip48(longint v);
    if (v > SAT_LIM) return SAT_LIM;
    if (v < -SAT_LIM) return -SAT_LIM;
    return v;
  endfunction

  function automatic longint qadd(longint a, longint b);
    return clip48(clip48(a) + clip48(b));
  endfunction

  // Sign-magnitude Q16.32 product, truncated toward zero, saturating.
  function automatic longint qmul(longint a, longint b);
    logic [63:0]  ma, mb;
    logic [127:0] prod;
    longint       m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    ma &= 64'hFFFF_FFFF_FFFF;
    mb &= 64'hFFFF_FFFF_FFFF;
    prod = (128'(ma) * 128'(mb)) >> 32;
    m = (prod > 128'(SAT_LIM)) ? SAT_LIM : longint'(prod);
    return (((a < 0) != (b < 0)) ? -m : m);
  endfunction

  // Interpolated logistic, Q0.32 result, argument magnitude clamped to 8.
  function automatic longint sigma(longint z);
    logic [63:0] mag, v, frac;
    int          k;
    mag = (z < 0) ? -z : z;
    if (mag >= 64'(8 * ONE_Q)) begin
      v = 64'(sigma_pts[16]) << 16;
    end else begin
      k = int'((mag >> 31) & 15);
      frac = mag & 64'h7FFF_FFFF;
      v = (64'(sigma_pts[k]) << 16) +
          ((64'(sigma_pts[k + 1] - sigma_pts[k]) * frac) >> 15);
    end
    if (z < 0) v = (64'd1 << 32) - v;
    return longint'(v);
  endfunction

  function automatic void reset_model();
    gain_q = 32'd655360;
    foreach (coef_q[i]) coef_q[i] = 0;
    for (int c = 0; c < NCH; c++) begin
      release_st[c] = R_RELEASE;
      depl_st[c]    = R_DEPL;
      calcium_st[c] = R_RELEASE;
      vesicle_st[c] = R_VES;
      rate_st[c]    = R_RATE;
    end
  endfunction

  // Advance one channel by one sample and return the scaled firing rate.
  function automatic logic [31:0] predict_rate(logic [5:0] ch, logic [31:0] smp);
    longint x, p, b, sumb, dep, cal, r, ves, res, d, out;
    x = qmul(longint'(signed'(smp)) * 65536, C_SCALE);
    if (x > C_CLIP) x = C_CLIP;
    p = sigma(qmul(C_TWOKS, qadd(x, -C_V0)));
    b = qmul(qadd(ONE_Q, -depl_st[ch]), p);
    sumb = qadd(b, release_st[ch]);
    dep = qmul(coef_q[0], qadd(qmul(C_K3K4, sumb), qmul(coef_q[1], depl_st[ch])));
    cal = qmul(coef_q[2], qadd(sumb, qmul(coef_q[3], calcium_st[ch])));
    r = qmul(qmul(cal, C_KR), qadd(C_N0, -vesicle_st[ch]));
    ves = qmul(coef_q[4], qadd(qmul(C_INVKP, qadd(r, rate_st[ch])),
                               qmul(coef_q[5], vesicle_st[ch])));
    if (r >= C_THR) begin
      d = qadd(r, -C_THR);
      res = qmul(d, sigma(qadd(d, d)));
    end else begin
      res = 0;
    end
    rate_st[ch] = res;
    release_st[ch] = b;
    depl_st[ch] = dep;
    calcium_st[ch] = cal;
    vesicle_st[ch] = ves;
    out = qmul(res, longint'(gain_q));
    return (out > 64'sh0FFFF_FFFF) ? 32'hFFFF_FFFF : out[31:0];
  endfunction

  // Result side: check every accepted item; stall on a pattern that
  // alternates between free-running stretches and stretches with random stalls.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) sb.check_result(channel_out_o, rate_o);
    if ((($time / 10) % 600) < 200) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  // Watchdog: counts cycles in which no item moves on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_GAIN) gain_q = val[31:0];
    else if (idx <= CFG_KB3) coef_q[idx - 1] = longint'(val);
    @(posedge clk_i);
  endtask

  task automatic send_sample(logic [5:0] ch, logic [31:0] smp);
    in_valid_i <= 1'b1;
    channel_i  <= ch;
    sample_i   <= smp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(ch, predict_rate(ch, smp));
  endtask

  // Sender idles between bursts; valid is only lowered at a gap.
  task automatic pause_sender();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 40)) @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending_rates.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_all(logic [31:0] g, logic [47:0] k[6]);
    write_reg(CFG_GAIN, 48'(g));
    for (int i = 0; i < 6; i++) write_reg(3'(i + 1), k[i]);
    // The unused index must leave every register alone.
    write_reg(3'd7, 48'hFFFF_FFFF_FFFF);
  endtask

  // Random part: mostly moderate potentials on a few channels so the filters
  // build up, with occasional full-range samples and any channel.
  task automatic random_phase(int n_items);
    int burst;
    logic [31:0] smp;
    logic [5:0] ch;
    burst = $urandom_range(1, 20);
    for (int i = 0; i < n_items; i++) begin
      ch = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) smp = $urandom;
      else smp = 32'($urandom_range(0, 32'h0060_0000)) - 32'h0010_0000;
      send_sample(ch, smp);
      if (--burst == 0) begin
        pause_sender();
        burst = $urandom_range(1, 20);
      end
    end
    in_valid_i <= 1'b0;
    drain();
  endtask

  initial begin
    logic [47:0] k[6];
    logic [31:0] edge_samples[8] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                     32'hFFFF_FFFF, 32'h005A_0000, 32'h002D_0000,
                                     32'hFFD0_0000, 32'h0001_0000};
    reset_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset coefficients give zero filters; then field extremes.
    foreach (edge_samples[i]) send_sample(6'(i * 9), edge_samples[i]);
    send_sample(6'd63, 32'h0050_0000);
    in_valid_i <= 1'b0;
    drain();

    // Typical coefficients between one half and one: rate rises over the threshold.
    k = '{48'h0_F000_0000, 48'h0_E000_0000, 48'h0_8000_0000,
          48'h0_C000_0000, 48'h1_0000_0000, 48'h0_F800_0000};
    write_all(32'd655360, k);
    for (int i = 0; i < 16; i++) begin
      send_sample(6'(i % 3), (i % 2) ? 32'h7FFF_FFFF : 32'h0040_0000);
      if (i % 5 == 4) pause_sender();
    end
    in_valid_i <= 1'b0;
    drain();
    random_phase(150);

    // Extremes: full-scale coefficients and gain drive every saturation.
    k = '{48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
          48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF};
    write_all(32'hFFFF_FFFF, k);
    random_phase(100);

    // A zero gain with fixed coefficients, then random coefficients and gain.
    write_all(32'd0, '{48'h1_0000_0000, 48'h0, 48'h2_0000_0000, 48'h0,
                       48'h1_0000_0000, 48'h0});
    random_phase(50);
    for (int i = 0; i < 6; i++) k[i] = 48'($urandom_range(0, 32'hFFFF_FFFF)) +
                                       (48'($urandom_range(0, 3)) << 32);
    write_all($urandom, k);
    random_phase(180);

    if (sb.mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
